/* sv/wsd_pkg.sv */
// package with shared types and constants of the websocket frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_REQUIRE_MASK = 1'b0;

    // header length codes
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [6:0] LEN7_MASK      = 7'h7F;
    localparam logic [3:0] OPCODE_MASK    = 4'hF;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_MASK = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // one classified result between front and back
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       byte_valid;
        logic       frame_last;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic [1:0] status;
    } wsd_rec_t;

endpackage

/* sv/wsd_if.sv */
// channel interfaces for received bytes and deframed results
`timescale 1ns / 1ps

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_last;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic [1:0] status;

    modport source (
        output valid, output payload_byte, output byte_valid, output frame_last,
        output fin_flag, output frame_opcode, output status, input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_valid, input frame_last,
        input fin_flag, input frame_opcode, input status, output ready
    );
endinterface

/* sv/wsd_front.sv */
// front end: frame header parser that classifies each received byte
`timescale 1ns / 1ps

module wsd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             require_mask,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             chunk_end,
    output logic             push_valid,
    output wsd_pkg::wsd_rec_t push_rec,
    input  logic             push_ready
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT_M   = 3'd2;
    localparam logic [2:0] PH_EXT_U   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic        hdr_fin_reg, hdr_fin_next;
    logic [3:0]  hdr_opcode_reg, hdr_opcode_next;
    logic [63:0] rem_len_reg, rem_len_next;
    logic [2:0]  fbc_reg, fbc_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  key_idx_reg, key_idx_next;
    logic        dropping_reg, dropping_next;

    logic        accept;
    logic        ce_eff;
    logic        emit;
    logic        masked;
    logic [6:0]  len7;
    logic [63:0] rem_shift;
    logic [7:0]  key_byte;
    wsd_rec_t    rec;

    assign in_ready  = push_ready;
    assign accept    = in_valid && push_ready;
    assign masked    = data_byte[7];
    assign len7      = data_byte[6:0] & LEN7_MASK;
    assign rem_shift = {rem_len_reg[55:0], data_byte};

    // key byte for the current payload position, first key byte on top
    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // per-byte parse step
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_fin_next    = hdr_fin_reg;
        hdr_opcode_next = hdr_opcode_reg;
        rem_len_next    = rem_len_reg;
        fbc_next        = fbc_reg;
        mask_key_next   = mask_key_reg;
        key_idx_next    = key_idx_reg;
        dropping_next   = dropping_reg;
        ce_eff          = chunk_end;
        emit            = 1'b0;
        rec             = '0;

        if (accept)
        begin
            if (dropping_reg)
            begin
                // discard until the end of the current chunk
                if (chunk_end)
                begin
                    dropping_next = 1'b0;
                    phase_next    = PH_HDR0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HDR1:
                    begin
                        if (!masked && require_mask)
                        begin
                            emit           = 1'b1;
                            rec.status     = ST_NO_MASK;
                            phase_next     = PH_HDR0;
                            dropping_next  = !chunk_end;
                            ce_eff         = 1'b0;
                        end
                        else if (len7 == LEN_CODE_EXT16 || len7 == LEN_CODE_EXT64)
                        begin
                            rem_len_next = '0;
                            fbc_next     = (len7 == LEN_CODE_EXT16) ? 3'd1 : 3'd7;
                            phase_next   = masked ? PH_EXT_M : PH_EXT_U;
                        end
                        else
                        begin
                            rem_len_next = {57'd0, len7};
                            if (masked)
                            begin
                                phase_next = PH_KEY;
                                fbc_next   = 3'd3;
                            end
                            else
                            begin
                                mask_key_next = '0;
                                key_idx_next  = '0;
                                if (len7 == 7'd0)
                                begin
                                    phase_next     = PH_HDR0;
                                    emit           = 1'b1;
                                    rec.frame_last = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_EXT_M, PH_EXT_U:
                    begin
                        rem_len_next = rem_shift;
                        if (fbc_reg == 3'd0)
                        begin
                            if (phase_reg == PH_EXT_M)
                            begin
                                phase_next = PH_KEY;
                                fbc_next   = 3'd3;
                            end
                            else
                            begin
                                mask_key_next = '0;
                                key_idx_next  = '0;
                                if (rem_shift == 64'd0)
                                begin
                                    phase_next     = PH_HDR0;
                                    emit           = 1'b1;
                                    rec.frame_last = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                        end
                        else
                        begin
                            fbc_next = fbc_reg - 3'd1;
                        end
                    end
                    PH_KEY:
                    begin
                        mask_key_next = {mask_key_reg[23:0], data_byte};
                        if (fbc_reg == 3'd0)
                        begin
                            key_idx_next = '0;
                            if (rem_len_reg == 64'd0)
                            begin
                                phase_next     = PH_HDR0;
                                emit           = 1'b1;
                                rec.frame_last = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            fbc_next = fbc_reg - 3'd1;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        emit           = 1'b1;
                        rec.data       = data_byte;
                        rec.key        = key_byte;
                        rec.byte_valid = 1'b1;
                        key_idx_next   = key_idx_reg + 2'd1;
                        rem_len_next   = rem_len_reg - 64'd1;
                        if (rem_len_reg == 64'd1)
                        begin
                            rec.frame_last = 1'b1;
                            phase_next     = PH_HDR0;
                        end
                    end
                    default:
                    begin
                        // first header byte
                        hdr_fin_next    = data_byte[7];
                        hdr_opcode_next = data_byte[3:0] & OPCODE_MASK;
                        rem_len_next    = '0;
                        fbc_next        = '0;
                        mask_key_next   = '0;
                        key_idx_next    = '0;
                        phase_next      = PH_HDR1;
                    end
                endcase

                // chunk ended inside a frame
                if (ce_eff && phase_next != PH_HDR0)
                begin
                    emit           = 1'b1;
                    rec.status     = ST_TRUNC;
                    rec.frame_last = 1'b0;
                    phase_next     = PH_HDR0;
                end
            end
        end

        rec.fin_flag     = hdr_fin_next;
        rec.frame_opcode = hdr_opcode_next;
    end

    assign push_valid = emit;
    assign push_rec   = rec;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            hdr_fin_reg    <= 1'b0;
            hdr_opcode_reg <= '0;
            rem_len_reg    <= '0;
            fbc_reg        <= '0;
            mask_key_reg   <= '0;
            key_idx_reg    <= '0;
            dropping_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_fin_reg    <= hdr_fin_next;
            hdr_opcode_reg <= hdr_opcode_next;
            rem_len_reg    <= rem_len_next;
            fbc_reg        <= fbc_next;
            mask_key_reg   <= mask_key_next;
            key_idx_reg    <= key_idx_next;
            dropping_reg   <= dropping_next;
        end
    end

    // payload phase always has bytes left to deliver
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_len_reg != 64'd0)
        else $error("payload phase with zero remaining length");

    // a missing-mask result never carries a payload byte or ends a frame
    a_nomask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_rec.status == ST_NO_MASK |->
            !push_rec.byte_valid && !push_rec.frame_last)
        else $error("malformed missing-mask result");

    // dropping always resumes at a frame start
    a_drop_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(dropping_reg) |-> phase_reg == PH_HDR0)
        else $error("dropping ended outside frame start");

    // key collection counts at most four bytes
    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_KEY |-> fbc_reg <= 3'd3)
        else $error("key byte count out of range");

endmodule

/* sv/wsd_queue.sv */
// two-entry result queue between parser and output stage
`timescale 1ns / 1ps

module wsd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  wsd_pkg::wsd_rec_t push_rec,
    output logic              push_ready,
    output logic              pop_valid,
    output wsd_pkg::wsd_rec_t pop_rec,
    input  logic              pop_ready
);
    import wsd_pkg::*;

    wsd_rec_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_rec    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* sv/wsd_back.sv */
// back end: unmasks payload bytes into the output register
`timescale 1ns / 1ps

module wsd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  wsd_pkg::wsd_rec_t pop_rec,
    output logic              pop_ready,
    wsd_out_if.source         out_ch
);
    import wsd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] payload_reg, payload_next;
    wsd_rec_t   rec_reg;

    // load whenever the output register is free or being drained
    assign pop_ready      = !out_valid_reg || out_ch.ready;
    assign out_valid_next = pop_ready ? pop_valid : out_valid_reg;
    assign payload_next   = pop_rec.byte_valid ? (pop_rec.data ^ pop_rec.key) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            payload_reg <= payload_next;
            rec_reg     <= pop_rec;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = payload_reg;
    assign out_ch.byte_valid   = rec_reg.byte_valid;
    assign out_ch.frame_last   = rec_reg.frame_last;
    assign out_ch.fin_flag     = rec_reg.fin_flag;
    assign out_ch.frame_opcode = rec_reg.frame_opcode;
    assign out_ch.status       = rec_reg.status;

endmodule

/* sv/websocket_frame_deframer_unit.sv */
// top level of the websocket frame deframer with its configuration port
// The deframer takes one byte of an established WebSocket connection per
// cycle and sustains one byte per cycle while the result side keeps up: the
// header parser updates its whole frame state on each accepted byte.
// That state includes the 64-bit remaining length count. A two-entry queue
// and the output register decouple the parser from the result side. They
// absorb a short result-side stall. The input is then held off while the
// queue is full, and resumes as soon as the queue holds fewer than two
// entries. A result is stored in the queue when its byte is accepted and
// is then loaded into the output register, which presents it at the output.
// Header, length and key bytes of a frame give no result.
// Payload bytes come out unmasked; empty frames give one result with
// frame_last set; a missing mask (when require_mask is 1) or a chunk end
// inside a frame is reported in status, and after a missing mask the rest
// of the chunk is dropped. require_mask lives at byte address 0.
`timescale 1ns / 1ps

module websocket_frame_deframer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [wsd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [wsd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    wsd_in_if.sink                        in_ch,
    wsd_out_if.source                     out_ch
);
    import wsd_pkg::*;

    logic     require_mask_reg, require_mask_next;
    logic     cfg_write;
    logic     cfg_sel_mask;
    logic     push_valid;
    logic     push_ready;
    wsd_rec_t push_rec;
    logic     pop_valid;
    logic     pop_ready;
    wsd_rec_t pop_rec;

    // configuration register access
    assign pready       = 1'b1;
    assign cfg_sel_mask = (paddr[CFG_ADDR_W-1] == CFG_IDX_REQUIRE_MASK);
    assign cfg_write    = psel && penable && pwrite && pready;
    assign require_mask_next = (cfg_write && cfg_sel_mask) ? pwdata[0] : require_mask_reg;
    assign prdata = cfg_sel_mask ? {{(CFG_DATA_W-1){1'b0}}, require_mask_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            require_mask_reg <= 1'b1;
        end
        else
        begin
            require_mask_reg <= require_mask_next;
        end
    end

    // header parser
    wsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .require_mask (require_mask_reg),
        .in_valid     (in_ch.valid),
        .in_ready     (in_ch.ready),
        .data_byte    (in_ch.data_byte),
        .chunk_end    (in_ch.chunk_end),
        .push_valid   (push_valid),
        .push_rec     (push_rec),
        .push_ready   (push_ready)
    );

    // decoupling queue
    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_rec    (pop_rec),
        .pop_ready  (pop_ready)
    );

    // unmask and output register
    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_rec   (pop_rec),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

/* tb/testbench.sv */
// self-checking testbench for the websocket frame deframer unit
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 170;
    localparam int RANDOM_PHASES  = 6;
    localparam int MAX_PAYLOAD    = 48;
    localparam logic [CFG_ADDR_W-1:0] REQUIRE_MASK_ADDR =
        CFG_ADDR_W'(4 * CFG_IDX_REQUIRE_MASK);

    // opcodes used by the directed frames
    localparam logic [3:0] OP_TEXT     = 4'h1;
    localparam logic [3:0] OP_CLOSE    = 4'h8;
    localparam logic [3:0] OP_PING     = 4'h9;
    localparam logic [3:0] OP_RESERVED = 4'hF;
    localparam logic [3:0] OP_CONT     = 4'h0;

    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXT_M, PH_EXT_U, PH_KEY, PH_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_last;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic [1:0] status;
    } deframed_t;

    // one received byte, with an optional hand-written expectation
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       typed;
        deframed_t  result;
    } rx_byte_t;

    localparam deframed_t NONE = '0;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    wsd_in_if  in_ch ();
    wsd_out_if out_ch ();

    websocket_frame_deframer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // parser state mirrored for prediction
    parse_phase_t ph = PH_HDR0;
    logic         cur_fin = 1'b0;
    logic [3:0]   cur_opcode = '0;
    logic [63:0]  bytes_left = '0;
    logic [2:0]   field_left = '0;
    logic [31:0]  key_word = '0;
    logic [1:0]   key_pos = '0;
    logic         skip_to_chunk_end = 1'b0;
    logic         require_mask_cfg = 1'b1;

    rx_byte_t  byte_stream[$];
    deframed_t expected_results[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    bit        pressure_req = 1'b0;

    // directed frames, run with require_mask at its reset value
    rx_byte_t directed_rows [25] = '{
        // empty masked ping frame, result on the last key byte
        '{8'h89, 1'b0, 1'b0, NONE},
        '{8'h80, 1'b0, 1'b0, NONE},
        '{8'h11, 1'b0, 1'b0, NONE},
        '{8'h22, 1'b0, 1'b0, NONE},
        '{8'h33, 1'b0, 1'b0, NONE},
        '{8'h44, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, OP_PING, ST_OK}},
        // mask bit missing, rest of the chunk dropped
        '{8'h8F, 1'b0, 1'b0, NONE},
        '{8'h05, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, OP_RESERVED, ST_NO_MASK}},
        '{8'h11, 1'b0, 1'b0, NONE},
        '{8'h22, 1'b1, 1'b0, NONE},
        // mask bit missing on a chunk end, nothing dropped
        '{8'h81, 1'b0, 1'b0, NONE},
        '{8'h7F, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, OP_TEXT, ST_NO_MASK}},
        // chunk end right after the first header byte
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, OP_CONT, ST_TRUNC}},
        // 16-bit extended length of one, masked
        '{8'h81, 1'b0, 1'b0, NONE},
        '{8'hFE, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'h01, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'h00, 1'b0, 1'b0, NONE},
        '{8'hA5, 1'b0, 1'b0, NONE},
        '{8'h5A, 1'b0, 1'b0, NONE},
        '{8'h0F, 1'b0, 1'b0, NONE},
        // 64-bit length cut off inside the length field
        '{8'h88, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b0, 1'b0, NONE},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, OP_CLOSE, ST_TRUNC}}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // header done: payload or an empty frame
    function automatic logic begin_payload();
        key_pos = '0;
        if (bytes_left == 0)
        begin
            ph = PH_HDR0;
            return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // length done: collect the key, or go straight to payload
    function automatic logic finish_length(input logic masked);
        if (masked)
        begin
            ph = PH_KEY;
            field_left = 3'd3;
            return 1'b0;
        end
        key_word = '0;
        return begin_payload();
    endfunction

    // advance the parser by one byte, returns 1 when a result is due
    function automatic logic deframe_byte(input logic [7:0] d, input logic ce_in,
                                          output deframed_t r);
        logic ce;
        logic emit;
        logic masked;
        logic [6:0] len7;
        ce = ce_in;
        emit = 1'b0;
        r = '0;
        if (skip_to_chunk_end)
        begin
            if (ce)
            begin
                skip_to_chunk_end = 1'b0;
                ph = PH_HDR0;
            end
            return 1'b0;
        end
        case (ph)
            PH_HDR1:
            begin
                masked = d[7];
                len7 = d[6:0] & LEN7_MASK;
                if (!masked && require_mask_cfg)
                begin
                    emit = 1'b1;
                    r.status = ST_NO_MASK;
                    ph = PH_HDR0;
                    skip_to_chunk_end = !ce;
                    ce = 1'b0;
                end
                else if (len7 == LEN_CODE_EXT16)
                begin
                    bytes_left = '0;
                    field_left = 3'd1;
                    ph = masked ? PH_EXT_M : PH_EXT_U;
                end
                else if (len7 == LEN_CODE_EXT64)
                begin
                    bytes_left = '0;
                    field_left = 3'd7;
                    ph = masked ? PH_EXT_M : PH_EXT_U;
                end
                else
                begin
                    bytes_left = 64'(len7);
                    emit = finish_length(masked);
                    r.frame_last = emit;
                end
            end
            PH_EXT_M, PH_EXT_U:
            begin
                bytes_left = {bytes_left[55:0], d};
                if (field_left == 0)
                begin
                    emit = finish_length(ph == PH_EXT_M);
                    r.frame_last = emit;
                end
                else
                    field_left = field_left - 3'd1;
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], d};
                if (field_left == 0)
                begin
                    emit = begin_payload();
                    r.frame_last = emit;
                end
                else
                    field_left = field_left - 3'd1;
            end
            PH_PAYLOAD:
            begin
                // key byte 0 is the first one received, held in the top bits
                r.payload_byte = d ^ key_word[8 * (3 - key_pos) +: 8];
                r.byte_valid = 1'b1;
                emit = 1'b1;
                key_pos = key_pos + 2'd1;
                bytes_left = bytes_left - 64'd1;
                if (bytes_left == 0)
                begin
                    r.frame_last = 1'b1;
                    ph = PH_HDR0;
                end
            end
            default:
            begin
                cur_fin = d[7];
                cur_opcode = d[3:0] & OPCODE_MASK;
                bytes_left = '0;
                field_left = '0;
                key_word = '0;
                key_pos = '0;
                ph = PH_HDR1;
            end
        endcase
        // chunk end inside a frame
        if (ce && ph != PH_HDR0)
        begin
            emit = 1'b1;
            r.status = ST_TRUNC;
            r.frame_last = 1'b0;
            ph = PH_HDR0;
        end
        r.fin_flag = cur_fin;
        r.frame_opcode = cur_opcode;
        return emit;
    endfunction

    // one frame, mostly well formed, sometimes cut short by a chunk end
    task automatic add_frame(input logic rm);
        logic [7:0] fb[$];
        logic [63:0] len;
        logic [6:0] code;
        logic masked;
        logic ce;
        int sel;
        int n;
        int cut;
        int i;
        masked = rm ? 1'($urandom_range(0, 15) != 0) : 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            len = 64'($urandom_range(0, 12));
            code = len[6:0];
        end
        else if (sel == 6)
        begin
            len = 64'($urandom_range(0, 125));
            code = len[6:0];
        end
        else if (sel < 9)
        begin
            len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                              : 64'($urandom_range(0, 40));
            code = LEN_CODE_EXT16;
        end
        else
        begin
            len = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                              : 64'($urandom_range(0, 30));
            code = LEN_CODE_EXT64;
        end
        fb.push_back(8'($urandom));
        fb.push_back({masked, code});
        if (code == LEN_CODE_EXT16)
            for (i = 1; i >= 0; i--)
                fb.push_back(len[8 * i +: 8]);
        else if (code == LEN_CODE_EXT64)
            for (i = 7; i >= 0; i--)
                fb.push_back(len[8 * i +: 8]);
        if (masked)
            repeat (4) fb.push_back(8'($urandom));
        n = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
        repeat (n) fb.push_back(8'($urandom));
        // long frames and rejected headers end their chunk early
        cut = -1;
        if (len > MAX_PAYLOAD || (!masked && rm))
            cut = fb.size() - 1;
        else if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(0, fb.size() - 1);
        for (i = 0; i < fb.size() && (cut < 0 || i <= cut); i++)
        begin
            ce = (i == cut) ||
                 (cut < 0 && i == fb.size() - 1 && $urandom_range(0, 3) == 0);
            byte_stream.push_back('{fb[i], ce, 1'b0, NONE});
        end
    endtask

    // garbage bytes, closed by a chunk end to get back in step
    task automatic add_noise();
        int n;
        logic ce;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            ce = (i == n - 1) || ($urandom_range(0, 3) == 0);
            byte_stream.push_back('{8'($urandom), ce, 1'b0, NONE});
        end
    endtask

    // offer every queued byte and predict each transfer
    task automatic send_stream();
        rx_byte_t  s;
        deframed_t r;
        logic      emit;
        @(negedge clk);
        while (byte_stream.size() != 0)
        begin
            s = byte_stream.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= s.data_byte;
            in_ch.chunk_end <= s.chunk_end;
            do @(posedge clk); while (!in_ch.ready);
            emit = deframe_byte(s.data_byte, s.chunk_end, r);
            if (s.typed)
                expected_results.push_back(s.result);
            else if (emit)
                expected_results.push_back(r);
            @(negedge clk);
        end
        in_ch.valid <= 1'b0;
    endtask

    // write require_mask once the block is idle, then read it back
    task automatic write_require_mask(input logic v);
        logic [CFG_DATA_W-1:0] rd;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REQUIRE_MASK_ADDR;
        pwdata <= CFG_DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        require_mask_cfg = v;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[0] !== v)
        begin
            $error("require_mask readback: expected %0d, actual %0d", v, rd[0]);
            fail_count++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                hold_left = HOLD_CYCLES;
                pressure_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        deframed_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: payload_byte 0x%0h status %0d",
                       out_ch.payload_byte, out_ch.status);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                check_field("payload_byte", e.payload_byte, out_ch.payload_byte);
                check_field("byte_valid", 8'(e.byte_valid), 8'(out_ch.byte_valid));
                check_field("frame_last", 8'(e.frame_last), 8'(out_ch.frame_last));
                check_field("fin_flag", 8'(e.fin_flag), 8'(out_ch.fin_flag));
                check_field("frame_opcode", 8'(e.frame_opcode), 8'(out_ch.frame_opcode));
                check_field("status", 8'(e.status), 8'(out_ch.status));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n)
            quiet_cycles = 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin : run
        int send_tbl [RANDOM_PHASES];
        int stall_tbl [RANDOM_PHASES];
        logic rm;
        send_tbl = '{0, 59, 0, 27, 0, 0};
        stall_tbl = '{0, 0, 59, 27, 0, 0};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.chunk_end = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames
        foreach (directed_rows[i])
            byte_stream.push_back(directed_rows[i]);
        send_stream();

        // random phases, alternating require_mask; phase 4 holds off the sink
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            rm = p[0];
            write_require_mask(rm);
            send_idle_pct = send_tbl[p];
            stall_pct = stall_tbl[p];
            while (byte_stream.size() < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 12)
                    add_noise();
                else
                    add_frame(rm);
            end
            if (p == 4)
                pressure_req = 1'b1;
            send_stream();
        end

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
